>>> rtl/core/assert_macros.svh
// Assertion helpers included by sexpr_token_scanner.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every rising clock edge outside reset.
`define STS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A same-cycle implication checked outside reset.
`define STS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/core/sts_pkg.sv
package sts_pkg;

  // Character codes.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Token kinds.
  localparam logic [3:0] K_INT   = 4'd0;
  localparam logic [3:0] K_ICHAR = 4'd1;
  localparam logic [3:0] K_IEND  = 4'd2;
  localparam logic [3:0] K_ARITH = 4'd3;
  localparam logic [3:0] K_CMP   = 4'd4;
  localparam logic [3:0] K_OPEN  = 4'd5;
  localparam logic [3:0] K_CLOSE = 4'd6;
  localparam logic [3:0] K_ERROR = 4'd7;
  localparam logic [3:0] K_END   = 4'd8;

  // Operator codes.
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_MOD = 4'd4;
  localparam logic [3:0] OP_EQ  = 4'd5;
  localparam logic [3:0] OP_LT  = 4'd6;
  localparam logic [3:0] OP_LE  = 4'd7;
  localparam logic [3:0] OP_GT  = 4'd8;
  localparam logic [3:0] OP_GE  = 4'd9;

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_NUMBER = 6'b000010,
    MODE_IDENT  = 6'b000100,
    MODE_MINUS  = 6'b001000,
    MODE_LT     = 6'b010000,
    MODE_GT     = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] value;
    logic [3:0]         op;
    logic               last;
  } token_t;

  // Up to two tokens handed from the scanner to the result queue per cycle.
  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              room2;
  } qstat_t;

  typedef struct packed {
    logic   emit;
    token_t tok;
    mode_t  mode;
    logic   start_num;
  } idle_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CH_UA) && (c <= CH_UZ);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return is_upper(c) || ((c >= CH_LA) && (c <= CH_LZ));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic signed [31:0] lower_code(input logic [7:0] c);
    logic [7:0] l;
    l = is_upper(c) ? (c + CASE_GAP) : c;
    return $signed({24'd0, l});
  endfunction

  function automatic token_t mk_tok(input logic [3:0] kind, input logic signed [31:0] value,
                                    input logic [3:0] op);
    token_t t;
    t.kind  = kind;
    t.value = value;
    t.op    = op;
    t.last  = 1'b0;
    return t;
  endfunction

  // Scan a byte from the idle state: what it emits and where it leaves the scanner.
  function automatic idle_res_t scan_idle(input logic [7:0] c);
    idle_res_t r;
    r.emit      = 1'b1;
    r.tok       = mk_tok(K_ERROR, $signed({24'd0, c}), OP_ADD);
    r.mode      = MODE_IDLE;
    r.start_num = 1'b0;
    if (c == CH_NUL) begin
      r.tok = mk_tok(K_END, '0, OP_ADD);
    end else if (is_space(c)) begin
      r.emit = 1'b0;
    end else if (is_digit(c)) begin
      r.emit      = 1'b0;
      r.mode      = MODE_NUMBER;
      r.start_num = 1'b1;
    end else if (is_alpha(c)) begin
      r.mode = MODE_IDENT;
      r.tok  = mk_tok(K_ICHAR, lower_code(c), OP_ADD);
    end else begin
      case (c)
        CH_MINUS: begin
          r.emit = 1'b0;
          r.mode = MODE_MINUS;
        end
        CH_LT: begin
          r.emit = 1'b0;
          r.mode = MODE_LT;
        end
        CH_GT: begin
          r.emit = 1'b0;
          r.mode = MODE_GT;
        end
        CH_PLUS:  r.tok = mk_tok(K_ARITH, '0, OP_ADD);
        CH_STAR:  r.tok = mk_tok(K_ARITH, '0, OP_MUL);
        CH_SLASH: r.tok = mk_tok(K_ARITH, '0, OP_DIV);
        CH_PCT:   r.tok = mk_tok(K_ARITH, '0, OP_MOD);
        CH_EQ:    r.tok = mk_tok(K_CMP, '0, OP_EQ);
        CH_OPEN:  r.tok = mk_tok(K_OPEN, '0, OP_ADD);
        CH_CLOSE: r.tok = mk_tok(K_CLOSE, '0, OP_ADD);
        default:  r.tok = mk_tok(K_ERROR, $signed({24'd0, c}), OP_ADD);
      endcase
    end
    return r;
  endfunction

endpackage

>>> rtl/core/sts_if.sv
interface sts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface sts_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic signed [31:0] value;
  logic [3:0]         operator;
  logic               last;

  modport source (output valid, output kind, output value, output operator, output last,
                  input ready);
  modport sink (input valid, input kind, input value, input operator, input last,
                output ready);
endinterface

>>> rtl/core/sts_scan.sv
module sts_scan
  import sts_pkg::*;
#(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  sts_in_if.sink    in_ch,
  input  qstat_t    qstat,
  output push_t     push
);

  localparam int EXT_W = (NUMBER_WIDTH > 32) ? NUMBER_WIDTH : 32;

  logic [7:0]              byte_r;
  logic                    full_r, full_nxt;
  mode_t                   mode_r, mode_nxt;
  logic [NUMBER_WIDTH-1:0] acc_r, acc_nxt;
  logic                    neg_r, neg_nxt;

  logic                    fire;
  logic                    in_take;
  logic [3:0]              digit;
  logic [NUMBER_WIDTH-1:0] acc_x10;
  logic [NUMBER_WIDTH-1:0] num_mag;
  logic signed [EXT_W-1:0] num_ext;
  idle_res_t               idl;
  logic                    pre_v;
  token_t                  pre_tok;
  logic                    use_idle;
  logic                    idle_v;

  // The held byte is scanned once the queue can take two tokens.
  assign fire        = full_r && qstat.room2;
  assign in_ch.ready = !full_r || qstat.room2;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign digit   = byte_r[3:0];
  assign acc_x10 = (acc_r << 3) + (acc_r << 1);
  assign num_mag = neg_r ? (NUMBER_WIDTH'(0) - acc_r) : acc_r;
  assign num_ext = EXT_W'($signed(num_mag));
  assign idl     = scan_idle(byte_r);

  always_comb begin
    full_nxt = in_take ? 1'b1 : (fire ? 1'b0 : full_r);
    pre_v    = 1'b0;
    pre_tok  = mk_tok(K_INT, '0, OP_ADD);
    use_idle = 1'b0;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    unique case (mode_r)
      MODE_NUMBER: begin
        if (is_digit(byte_r)) begin
          acc_nxt = acc_x10 + NUMBER_WIDTH'(digit);
        end else begin
          pre_v    = 1'b1;
          pre_tok  = mk_tok(K_INT, $signed(num_ext[31:0]), OP_ADD);
          use_idle = 1'b1;
        end
      end
      MODE_MINUS: begin
        if (is_digit(byte_r)) begin
          mode_nxt = MODE_NUMBER;
          acc_nxt  = NUMBER_WIDTH'(digit);
          neg_nxt  = 1'b1;
        end else begin
          pre_v    = 1'b1;
          pre_tok  = mk_tok(K_ARITH, '0, OP_SUB);
          use_idle = 1'b1;
        end
      end
      MODE_IDENT: begin
        pre_v = 1'b1;
        if (is_alpha(byte_r) || is_digit(byte_r)) begin
          pre_tok = mk_tok(K_ICHAR, lower_code(byte_r), OP_ADD);
        end else begin
          pre_tok  = mk_tok(K_IEND, '0, OP_ADD);
          use_idle = 1'b1;
        end
      end
      MODE_LT, MODE_GT: begin
        pre_v = 1'b1;
        if (byte_r == CH_EQ) begin
          mode_nxt = MODE_IDLE;
          pre_tok  = mk_tok(K_CMP, '0, (mode_r == MODE_LT) ? OP_LE : OP_GE);
        end else begin
          pre_tok  = mk_tok(K_CMP, '0, (mode_r == MODE_LT) ? OP_LT : OP_GT);
          use_idle = 1'b1;
        end
      end
      default: begin
        use_idle = 1'b1;
      end
    endcase
    if (use_idle) begin
      mode_nxt = idl.mode;
      if (idl.start_num) begin
        acc_nxt = NUMBER_WIDTH'(digit);
        neg_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    idle_v         = use_idle && idl.emit;
    push.cnt       = fire ? (2'(pre_v) + 2'(idle_v)) : 2'd0;
    push.tok0      = pre_v ? pre_tok : idl.tok;
    push.tok0.last = !(pre_v && idle_v);
    push.tok1      = idl.tok;
    push.tok1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      neg_r  <= 1'b0;
    end else begin
      full_r <= full_nxt;
      if (fire) begin
        mode_r <= mode_nxt;
        acc_r  <= acc_nxt;
        neg_r  <= neg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_ch.char_code;
    end
  end

endmodule

>>> rtl/core/sts_queue.sv
module sts_queue
  import sts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  output qstat_t    qstat,
  sts_out_if.source out_ch
);

  token_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                pop;
  token_t              head;

  assign pop  = (count_r != '0) && out_ch.ready;
  assign head = mem[rd_ptr_r];

  assign out_ch.valid    = (count_r != '0);
  assign out_ch.kind     = head.kind;
  assign out_ch.value    = head.value;
  assign out_ch.operator = head.op;
  assign out_ch.last     = head.last;

  assign qstat.count = count_r;
  assign qstat.room2 = (count_r <= QCNT_W'(QDEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(push.cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.tok0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_r + QPTR_W'(1)] <= push.tok1;
    end
  end

endmodule

>>> rtl/core/sexpr_token_scanner.sv
// The first token of a byte is offered once the byte has passed the input byte
// register and the result queue. Throughput: one byte per cycle while the output
// is ready and each byte gives at most one token; a byte that ends one token and
// emits another puts two tokens in the four-entry result queue, read one at a time.
// Reset (synchronous, active low): scanner idle, accumulator and sign cleared,
// input register and result queue empty.
`include "assert_macros.svh"

module sexpr_token_scanner
  import sts_pkg::*;
#(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  sts_in_if.sink    in_ch,
  sts_out_if.source out_ch
);

  push_t  push;
  qstat_t qstat;

  sts_scan #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .qstat (qstat),
    .push  (push)
  );

  sts_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .qstat  (qstat),
    .out_ch (out_ch)
  );

  `STS_ASSERT(a_queue_bound, qstat.count <= QCNT_W'(QDEPTH), "result queue overflow")
  `STS_ASSERT_IMP(a_push_room, push.cnt != 2'd0, qstat.room2, "token pushed without room")
  `STS_ASSERT_IMP(a_pair_last, push.cnt == 2'd2, !push.tok0.last && push.tok1.last,
                  "last flag misplaced on a token pair")

endmodule
